### design/i2cdbw_pkg.sv
// Shared types and constants for the I2C display byte writer.
// No dependencies; every other file imports this package.
package i2cdbw_pkg;

  localparam logic [7:0] DEV_ADDR_RESET = 8'h78;
  localparam logic [7:0] CTRL_DATA      = 8'h40;
  localparam logic [7:0] CTRL_CMD       = 8'h00;
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned QPTR_W        = $clog2(QDEPTH);
  localparam int unsigned QCNT_W        = $clog2(QDEPTH + 1);
  localparam int unsigned FRAME_W       = 24;
  localparam int unsigned NUM_BYTES     = FRAME_W / 8;
  localparam int unsigned BYTE_IDX_W    = $clog2(NUM_BYTES);

  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_BIT   = 2'd1,
    SYM_ACK   = 2'd2,
    SYM_STOP  = 2'd3
  } sym_kind_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_data;
  } in_item_t;

  typedef struct packed {
    sym_kind_e symbol_kind;
    logic      sda_level;
    logic      last;
  } out_item_t;

  // Three bytes of one transaction, address byte in the top bits.
  typedef struct packed {
    logic [FRAME_W-1:0] bits;
  } frame_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_head_t;

endpackage

### design/i2cdbw_front.sv
// Front end: holds the device address register and turns an input item
// into a three-byte transaction frame. Depends on i2cdbw_pkg.
module i2cdbw_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [7:0]           cfg_data_i,
  input  i2cdbw_pkg::in_item_t in_item_i,
  output i2cdbw_pkg::frame_t   frame_o
);
  import i2cdbw_pkg::*;

  logic [7:0] dev_addr_q;
  logic [7:0] ctrl_byte;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RESET;
    end else if (cfg_valid_i) begin
      dev_addr_q <= cfg_data_i;
    end
  end

  // Pick the control byte from the data/command flag.
  assign ctrl_byte    = in_item_i.is_data ? CTRL_DATA : CTRL_CMD;
  assign frame_o.bits = {dev_addr_q, ctrl_byte, in_item_i.payload_byte};

endmodule

### design/i2cdbw_queue.sv
// Short frame queue between front and back end.
// Depends on i2cdbw_pkg.
module i2cdbw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  i2cdbw_pkg::frame_t  frame_i,
  output logic                full_o,
  input  logic                rd_i,
  output i2cdbw_pkg::q_head_t head_o
);
  import i2cdbw_pkg::*;

  frame_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_wr, do_rd;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign do_wr        = wr_i && !full_o;
  assign do_rd        = rd_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.frame = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

endmodule

### design/i2cdbw_back.sv
// Back end: serializes one frame into start, 3 x (8 bits + ack), stop.
// Depends on i2cdbw_pkg.
module i2cdbw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cdbw_pkg::q_head_t   head_i,
  output logic                  deq_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output i2cdbw_pkg::out_item_t out_item_o
);
  import i2cdbw_pkg::*;

  typedef enum logic [3:0] {
    ST_START = 4'b0001,
    ST_BIT   = 4'b0010,
    ST_ACK   = 4'b0100,
    ST_STOP  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [FRAME_W-1:0]    sh_q, sh_d;
  logic [2:0]            bit_q, bit_d;
  logic [BYTE_IDX_W-1:0] byte_q, byte_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;
  logic                  load_ok, emit;

  // Output register frees up when empty or being popped this cycle.
  assign load_ok = !out_valid_q || pop_i;

  always_comb begin
    state_d     = state_q;
    sh_d        = sh_q;
    bit_d       = bit_q;
    byte_d      = byte_q;
    out_d       = out_q;
    emit        = 1'b0;
    deq_o       = 1'b0;
    unique case (state_q)
      ST_START: begin
        if (head_i.valid && load_ok) begin
          emit    = 1'b1;
          deq_o   = 1'b1;
          out_d   = '{symbol_kind: SYM_START, sda_level: 1'b0, last: 1'b0};
          sh_d    = head_i.frame.bits;
          bit_d   = '0;
          byte_d  = '0;
          state_d = ST_BIT;
        end
      end
      ST_BIT: begin
        if (load_ok) begin
          emit    = 1'b1;
          out_d   = '{symbol_kind: SYM_BIT, sda_level: sh_q[FRAME_W-1], last: 1'b0};
          sh_d    = {sh_q[FRAME_W-2:0], 1'b0};
          bit_d   = bit_q + 1'b1;
          if (bit_q == 3'd7) begin
            state_d = ST_ACK;
          end
        end
      end
      ST_ACK: begin
        if (load_ok) begin
          emit  = 1'b1;
          out_d = '{symbol_kind: SYM_ACK, sda_level: 1'b1, last: 1'b0};
          if (byte_q == BYTE_IDX_W'(NUM_BYTES - 1)) begin
            state_d = ST_STOP;
          end else begin
            byte_d  = byte_q + 1'b1;
            state_d = ST_BIT;
          end
        end
      end
      ST_STOP: begin
        if (load_ok) begin
          emit    = 1'b1;
          out_d   = '{symbol_kind: SYM_STOP, sda_level: 1'b0, last: 1'b1};
          state_d = ST_START;
        end
      end
      default: state_d = ST_START;
    endcase
    out_valid_d = emit || (out_valid_q && !pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      bit_q       <= '0;
      byte_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      byte_q      <= byte_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    out_q <= out_d;
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  // A frame taken from the queue shows up as a start symbol next cycle.
  a_deq_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |=> (out_valid_q && out_q.symbol_kind == SYM_START))
    else $error("dequeue not followed by start symbol");

  // The last flag marks only the stop symbol, and stop always carries it.
  a_last_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last == (out_q.symbol_kind == SYM_STOP)))
    else $error("last flag out of step with stop symbol");

  // An ack slot ending the payload byte leads straight to the stop symbol.
  a_ack_to_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACK && load_ok && byte_q == BYTE_IDX_W'(NUM_BYTES - 1))
      |=> (state_q == ST_STOP))
    else $error("missing stop after last ack");

endmodule

### design/i2c_display_byte_writer.sv
// I2C display byte writer: each item becomes 29 bus symbols, 1 per cycle while pop keeps up.
// An accepted item is written to the queue; its start symbol is then registered in the back end.
// The back-end serializer takes a new frame only after the stop symbol of the last one.
// Two frames queue between front and back, so push stays open meanwhile.
// Reset: async active-low; address resets to 0x78, queue and output empty.
module i2c_display_byte_writer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  i2cdbw_pkg::in_item_t  in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output i2cdbw_pkg::out_item_t out_item_o
);
  import i2cdbw_pkg::*;

  frame_t  frame;
  q_head_t head;
  logic    deq;

  // Front end: hold the address register and build the frame on accept.
  i2cdbw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .frame_o     (frame)
  );

  // Queue decouples acceptance from serialization; full backs up push.
  i2cdbw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .frame_i (frame),
    .full_o  (full),
    .rd_i    (deq),
    .head_o  (head)
  );

  // Back end: advance one symbol per cycle into the output register while pop keeps it free.
  i2cdbw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .deq_o      (deq),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule
